[hdl/tare_pkg.sv]
// ----------------------------------------------------------------------------
// tare_pkg
// Types and codes shared by the alarm rule engine modules.
// ----------------------------------------------------------------------------
package tare_pkg;

   typedef enum logic [2:0] {
      OP_ADD_COMPARE = 3'd0,
      OP_ADD_STALE   = 3'd1,
      OP_SAMPLE      = 3'd2,
      OP_CHECK_STALE = 3'd3,
      OP_CLEAR       = 3'd4
   } op_type;

   localparam logic [2:0] CMP_GT    = 3'd0;
   localparam logic [2:0] CMP_GTE   = 3'd1;
   localparam logic [2:0] CMP_LT    = 3'd2;
   localparam logic [2:0] CMP_LTE   = 3'd3;
   localparam logic [2:0] CMP_EQ    = 3'd4;
   localparam logic [2:0] CMP_NEQ   = 3'd5;
   localparam logic [2:0] CMP_STALE = 3'd6;

   localparam logic [1:0] LEVEL_INFO  = 2'd0;
   localparam logic [1:0] LEVEL_WARN  = 2'd1;
   localparam logic [1:0] LEVEL_ERROR = 2'd2;
   localparam logic [1:0] LEVEL_BAD   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_WALK    = 2'd1,
      ST_SUMMARY = 2'd2
   } state_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [15:0]        key_id;
      logic [2:0]         compare_op;
      logic signed [47:0] threshold;
      logic [1:0]         alarm_level;
      logic [15:0]        event_code;
      logic [46:0]        cooldown;
      logic signed [47:0] sample_value;
      logic [31:0]        current_time;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               is_last;
      logic [3:0]         rule_index;
      logic [15:0]        fired_event;
      logic [1:0]         fired_level;
      logic signed [47:0] fired_threshold;
      logic signed [47:0] event_value;
      logic [4:0]         emitted_count;
      logic [31:0]        samples_total;
      logic [31:0]        info_total;
      logic [31:0]        warn_total;
      logic [31:0]        error_total;
   } rsp_type;

   // rule fields fixed at add time
   typedef struct packed {
      logic [15:0]        key;
      logic [2:0]         compare;
      logic signed [47:0] threshold;
      logic [1:0]         level;
      logic [15:0]        event_code;
      logic [46:0]        cooldown;
   } rule_type;

   // rule fields that a walk updates
   typedef struct packed {
      logic [31:0] last_emit;
      logic        has_emit;
      logic        seen;
   } track_type;

   typedef struct packed {
      logic      fire;
      logic      touch;
      track_type track;
   } eval_type;

endpackage

[hdl/tare_ram.sv]
// ----------------------------------------------------------------------------
// tare_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tare_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/tare_eval.sv]
// ----------------------------------------------------------------------------
// tare_eval
// Match, comparison and cooldown test of one rule against the current beat.
// ----------------------------------------------------------------------------
module tare_eval (
   input  logic                  is_sample,
   input  logic [15:0]           key,
   input  logic signed [47:0]    value,
   input  logic [31:0]           now,
   input  tare_pkg::rule_type    rule,
   input  tare_pkg::track_type   track,
   output tare_pkg::eval_type    result
);

   logic               is_stale;
   logic               key_hit;
   logic               cmp_hit;
   logic               cooling;
   logic signed [32:0] diff;
   logic signed [48:0] elapsed;
   logic               candidate;

   always_comb begin
      is_stale = (rule.compare == tare_pkg::CMP_STALE);
      key_hit  = (rule.key == key);
      case (rule.compare)
         tare_pkg::CMP_GT:    cmp_hit = value > rule.threshold;
         tare_pkg::CMP_GTE:   cmp_hit = value >= rule.threshold;
         tare_pkg::CMP_LT:    cmp_hit = value < rule.threshold;
         tare_pkg::CMP_LTE:   cmp_hit = value <= rule.threshold;
         tare_pkg::CMP_EQ:    cmp_hit = value == rule.threshold;
         tare_pkg::CMP_NEQ:   cmp_hit = value != rule.threshold;
         tare_pkg::CMP_STALE: cmp_hit = value > rule.threshold;
         default:             cmp_hit = 1'b0;
      endcase

      diff    = $signed({1'b0, now}) - $signed({1'b0, track.last_emit});
      elapsed = {diff, 16'h0000};
      cooling = (rule.cooldown != '0) && track.has_emit
                && (elapsed < $signed({2'b00, rule.cooldown}));

      if (is_sample) begin
         candidate    = key_hit && cmp_hit;
         result.touch = key_hit;
      end else begin
         candidate    = is_stale && !track.seen;
         result.touch = candidate;
      end
      result.fire = candidate && !cooling;

      result.track = track;
      if (is_sample && key_hit && is_stale) begin
         result.track.seen = 1'b1;
      end
      if (result.fire) begin
         result.track.last_emit = now;
         result.track.has_emit  = 1'b1;
      end
   end

endmodule

[hdl/threshold_alarm_rule_engine_top.sv]
// ----------------------------------------------------------------------------
// threshold_alarm_rule_engine_top
// Alarm rule table with sample, stale check, add and clear operations.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. Add, clear and unused operations, and
// sample or stale check on an empty table, go straight to the summary state,
// which loads their single summary beat and raises rsp_valid once the output
// is free; the next request is taken when the engine is back in idle. Sample
// and stale check walk the rule RAMs one entry per cycle while no event beat
// is held by a stalled output, holding on an entry whose event beat cannot be
// loaded. Each request ends with one summary beat carrying status and the
// wrapping counters; event beats come before it in rule order. No clearing
// pass is needed after reset.
module threshold_alarm_rule_engine_top #(
   parameter int MAX_RULES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tare_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tare_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W = $clog2(MAX_RULES + 1);

   tare_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [4:0]          emitted_ff, emitted_in;
   logic [1:0]          status_ff, status_in;
   logic [31:0]         samples_ff, samples_in;
   logic [31:0]         info_ff, info_in;
   logic [31:0]         warn_ff, warn_in;
   logic [31:0]         error_ff, error_in;
   tare_pkg::req_type   req_ff, req_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tare_pkg::rsp_type   rsp_ff, rsp_in;

   logic                rule_we;
   logic [IDX_W-1:0]    rule_waddr;
   tare_pkg::rule_type  rule_wdata, rule_rdata;
   logic                track_we;
   logic [IDX_W-1:0]    track_waddr;
   tare_pkg::track_type track_wdata, track_rdata;
   logic [IDX_W-1:0]    rd_addr;

   tare_pkg::eval_type  eval;
   logic                out_free;
   logic                bad;
   logic                advance;
   logic [IDX_W+3:0]    idx_wide;

   tare_ram #(
      .DEPTH (MAX_RULES),
      .WIDTH ($bits(tare_pkg::rule_type)),
      .ADDR_W(IDX_W)
   ) u_rule_ram (
      .clock  (clock),
      .wr_en  (rule_we),
      .wr_addr(rule_waddr),
      .wr_data(rule_wdata),
      .rd_addr(rd_addr),
      .rd_data(rule_rdata)
   );

   tare_ram #(
      .DEPTH (MAX_RULES),
      .WIDTH ($bits(tare_pkg::track_type)),
      .ADDR_W(IDX_W)
   ) u_track_ram (
      .clock  (clock),
      .wr_en  (track_we),
      .wr_addr(track_waddr),
      .wr_data(track_wdata),
      .rd_addr(rd_addr),
      .rd_data(track_rdata)
   );

   tare_eval u_eval (
      .is_sample(req_ff.operation == tare_pkg::OP_SAMPLE),
      .key      (req_ff.key_id),
      .value    (req_ff.sample_value),
      .now      (req_ff.current_time),
      .rule     (rule_rdata),
      .track    (track_rdata),
      .result   (eval)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tare_pkg::ST_IDLE;
         count_ff     <= '0;
         samples_ff   <= '0;
         info_ff      <= '0;
         warn_ff      <= '0;
         error_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         samples_ff   <= samples_in;
         info_ff      <= info_in;
         warn_ff      <= warn_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      emitted_ff <= emitted_in;
      status_ff  <= status_in;
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      emitted_in   = emitted_ff;
      status_in    = status_ff;
      samples_in   = samples_ff;
      info_in      = info_ff;
      warn_in      = warn_ff;
      error_in     = error_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rule_we      = 1'b0;
      rule_waddr   = count_ff[IDX_W-1:0];
      rule_wdata   = '{key:        req_data.key_id,
                       compare:    req_data.compare_op,
                       threshold:  req_data.threshold,
                       level:      req_data.alarm_level,
                       event_code: req_data.event_code,
                       cooldown:   req_data.cooldown};
      track_we     = 1'b0;
      track_waddr  = idx_ff;
      track_wdata  = eval.track;
      rd_addr      = idx_ff;
      bad          = 1'b0;
      advance      = 1'b0;
      idx_wide     = {4'b0000, idx_ff};

      case (state_ff)
         tare_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               emitted_in = '0;
               status_in  = tare_pkg::STATUS_OK;
               idx_in     = '0;
               rd_addr    = '0;
               state_in   = tare_pkg::ST_SUMMARY;
               case (req_data.operation)
                  tare_pkg::OP_ADD_COMPARE, tare_pkg::OP_ADD_STALE: begin
                     if (req_data.operation == tare_pkg::OP_ADD_COMPARE) begin
                        bad = (req_data.compare_op > tare_pkg::CMP_NEQ);
                     end else begin
                        bad = (req_data.threshold < 0);
                        rule_wdata.compare = tare_pkg::CMP_STALE;
                     end
                     bad = bad || (req_data.alarm_level == tare_pkg::LEVEL_BAD);
                     if (bad) begin
                        status_in = tare_pkg::STATUS_INVALID;
                     end else if (count_ff >= CNT_W'(MAX_RULES)) begin
                        status_in = tare_pkg::STATUS_FULL;
                     end else begin
                        rule_we     = 1'b1;
                        track_we    = 1'b1;
                        track_waddr = count_ff[IDX_W-1:0];
                        track_wdata = '0;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  tare_pkg::OP_SAMPLE: begin
                     samples_in = samples_ff + 1'b1;
                     if (count_ff != '0) begin
                        state_in = tare_pkg::ST_WALK;
                     end
                  end
                  tare_pkg::OP_CHECK_STALE: begin
                     if (count_ff != '0) begin
                        state_in = tare_pkg::ST_WALK;
                     end
                  end
                  tare_pkg::OP_CLEAR: begin
                     count_in   = '0;
                     samples_in = '0;
                     info_in    = '0;
                     warn_in    = '0;
                     error_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         tare_pkg::ST_WALK: begin
            // hold on this entry while an event beat cannot be loaded
            advance = !eval.fire || out_free;
            if (advance) begin
               track_we = eval.touch;
               if (eval.fire) begin
                  rsp_valid_in           = 1'b1;
                  rsp_in                 = '0;
                  rsp_in.rule_index      = idx_wide[3:0];
                  rsp_in.fired_event     = rule_rdata.event_code;
                  rsp_in.fired_level     = rule_rdata.level;
                  rsp_in.fired_threshold = rule_rdata.threshold;
                  rsp_in.event_value     = (req_ff.operation == tare_pkg::OP_SAMPLE)
                                           ? req_ff.sample_value : rule_rdata.threshold;
                  emitted_in             = emitted_ff + 1'b1;
                  case (rule_rdata.level)
                     tare_pkg::LEVEL_INFO:  info_in  = info_ff + 1'b1;
                     tare_pkg::LEVEL_WARN:  warn_in  = warn_ff + 1'b1;
                     tare_pkg::LEVEL_ERROR: error_in = error_ff + 1'b1;
                     default: begin
                     end
                  endcase
               end
               if ((CNT_W'(idx_ff) + 1'b1) == count_ff) begin
                  state_in = tare_pkg::ST_SUMMARY;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end

         tare_pkg::ST_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.status        = status_ff;
               rsp_in.is_last       = 1'b1;
               rsp_in.emitted_count = emitted_ff;
               rsp_in.samples_total = samples_ff;
               rsp_in.info_total    = info_ff;
               rsp_in.warn_total    = warn_ff;
               rsp_in.error_total   = error_ff;
               state_in             = tare_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tare_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != tare_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
